/* hdl/cfr_pkg.sv */
// Package with the shared types and constants of the carrier frame receiver.
`default_nettype none

package cfr_pkg;

  // Frame delimiters.
  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [7:0] END_BYTE   = 8'h16;

  // Configuration register indexes.
  localparam logic CFG_IDX_LENGTH_BYTES = 1'b0;
  localparam logic CFG_IDX_MAX_LENGTH   = 1'b1;

  // Configuration reset values.
  localparam logic [1:0]  LENGTH_BYTES_RESET = 2'd1;
  localparam logic [15:0] MAX_LENGTH_RESET   = 16'd512;

  // Smallest frame beyond the length field: start, control, checksum, end.
  localparam logic [16:0] MIN_LENGTH_BASE = 17'd4;

  // Receiver phase.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } cfr_phase_e;

  // Error codes reported on the final result of a frame.
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_LENGTH   = 2'd1,
    ERR_CHECKSUM = 2'd2,
    ERR_END_BYTE = 2'd3
  } cfr_error_e;

  // One result transaction.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] position;
    logic        last;
    logic        good;
    logic [1:0]  error_code;
  } cfr_result_t;

  // Result handed from the parser to the output register.
  typedef struct packed {
    logic        valid;
    cfr_result_t data;
  } cfr_step_t;

endpackage

`default_nettype wire

/* hdl/cfr_if.sv */
// Stream interfaces for received bytes and for frame results.
`default_nettype none

interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [15:0] position;
  logic        last;
  logic        good;
  logic [1:0]  error_code;

  modport source (output valid, output out_byte, output position, output last,
                  output good, output error_code, input ready);
  modport sink   (input valid, input out_byte, input position, input last,
                  input good, input error_code, output ready);
endinterface

`default_nettype wire

/* hdl/cfr_parser.sv */
// Frame parser: configuration registers, frame state and the per-byte step logic.
`default_nettype none

module cfr_parser
  import cfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        accept_i,
  input  wire logic [7:0]  in_byte_i,
  output cfr_step_t        step_o
);

  logic [1:0]  length_bytes_q;
  logic [15:0] max_length_q;

  cfr_phase_e  phase_q, phase_d;
  logic [15:0] remaining_q, remaining_d;
  logic [15:0] frame_pos_q, frame_pos_d;
  logic [15:0] frame_len_q, frame_len_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  prev_q, prev_d;

  logic [15:0] len_field;
  logic [16:0] min_len;
  logic        len_bad;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_bytes_q <= LENGTH_BYTES_RESET;
      max_length_q   <= MAX_LENGTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDX_LENGTH_BYTES: length_bytes_q <= cfg_data_i[1:0];
        CFG_IDX_MAX_LENGTH:   max_length_q   <= cfg_data_i;
        default:              length_bytes_q <= length_bytes_q;
      endcase
    end
  end

  // Length field as assembled so far, little-endian.
  assign len_field = (frame_pos_q == 16'd1) ? {8'h00, in_byte_i}
                                            : {in_byte_i, frame_len_q[7:0]};

  // Length check against the smallest and largest allowed frame.
  assign min_len = {1'b0, frame_pos_q} + MIN_LENGTH_BASE;
  assign len_bad = ({1'b0, len_field} < min_len) || (len_field > max_length_q);

  // Next state and result for the byte in flight.
  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    frame_pos_d = frame_pos_q;
    frame_len_d = frame_len_q;
    sum_d       = sum_q;
    prev_d      = prev_q;

    step_o                 = '0;
    step_o.data.out_byte   = in_byte_i;
    step_o.data.position   = frame_pos_q;
    step_o.data.error_code = ERR_NONE;

    case (phase_q)
      PH_LEN: begin
        step_o.valid = 1'b1;
        frame_len_d  = len_field;
        frame_pos_d  = frame_pos_q + 16'd1;
        remaining_d  = remaining_q - 16'd1;
        if (remaining_q == 16'd1) begin
          if (len_bad) begin
            phase_d                = PH_HUNT;
            step_o.data.last       = 1'b1;
            step_o.data.error_code = ERR_LENGTH;
          end else begin
            remaining_d = len_field - 16'd1 - frame_pos_q;
            sum_d       = 8'h00;
            prev_d      = 8'h00;
            phase_d     = PH_BODY;
          end
        end
      end

      PH_BODY: begin
        step_o.valid = 1'b1;
        frame_pos_d  = frame_pos_q + 16'd1;
        if (remaining_q >= 16'd3) begin
          sum_d = sum_q + in_byte_i;
        end else if (remaining_q == 16'd2) begin
          prev_d = in_byte_i;
        end
        remaining_d = remaining_q - 16'd1;
        if (remaining_q == 16'd1) begin
          phase_d          = PH_HUNT;
          step_o.data.last = 1'b1;
          if (prev_q != sum_q) begin
            step_o.data.error_code = ERR_CHECKSUM;
          end else if (in_byte_i != END_BYTE) begin
            step_o.data.error_code = ERR_END_BYTE;
          end else begin
            step_o.data.good = 1'b1;
          end
        end
      end

      default: begin
        // Hunting; the unused phase code behaves the same way.
        phase_d = PH_HUNT;
        if (in_byte_i == START_BYTE) begin
          step_o.valid         = 1'b1;
          step_o.data.position = 16'd0;
          frame_pos_d          = 16'd1;
          frame_len_d          = 16'd0;
          sum_d                = 8'h00;
          prev_d               = 8'h00;
          remaining_d          = length_bytes_q[1] ? 16'd2 : 16'd1;
          phase_d              = PH_LEN;
        end
      end
    endcase
  end

  // Frame state advances on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      remaining_q <= 16'd0;
      frame_pos_q <= 16'd0;
      frame_len_q <= 16'd0;
      sum_q       <= 8'h00;
      prev_q      <= 8'h00;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      frame_pos_q <= frame_pos_d;
      frame_len_q <= frame_len_d;
      sum_q       <= sum_d;
      prev_q      <= prev_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/cfr_out_reg.sv */
// Result register that holds one result transaction until the sink takes it.
`default_nettype none

module cfr_out_reg
  import cfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire cfr_result_t data_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output cfr_result_t      data_o,
  output logic             free_o
);

  logic        valid_q, valid_d;
  cfr_result_t data_q;

  // The register can take a new result when empty or being drained.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

endmodule

`default_nettype wire

/* hdl/carrier_frame_receiver.sv */
// Top level of the carrier frame receiver: parser and result register.
//
//   Channel  Dir  Handshake     Payload
//   in_i     in   valid/ready   in_byte
//   out_o    out  valid/ready   out_byte, position, last, good, error_code
//   cfg      in   cfg_we_i      cfg_index_i, cfg_data_i
//
// One byte is accepted per cycle unless stalled; its result, if any, appears in
// the result register on the next cycle. The frame state update is a single add
// and compare path between the frame registers and the result register.
// Reset puts the parser in hunt mode with length_bytes 1 and max_length 512.
// A stalled result holds the input back only when the result register is full.
`default_nettype none

module carrier_frame_receiver
  import cfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  cfr_in_if.sink           in_i,
  cfr_out_if.source        out_o
);

  cfr_step_t   step;
  cfr_result_t out_data;
  logic        free;
  logic        accept;
  logic        out_valid;

  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  cfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_byte_i   (in_i.in_byte),
    .step_o      (step)
  );

  cfr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && step.valid),
    .data_i      (step.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .data_o      (out_data),
    .free_o      (free)
  );

  // Drive the result channel.
  assign out_o.valid      = out_valid;
  assign out_o.out_byte   = out_data.out_byte;
  assign out_o.position   = out_data.position;
  assign out_o.last       = out_data.last;
  assign out_o.good       = out_data.good;
  assign out_o.error_code = out_data.error_code;

  // An error is only reported on the final result of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.error_code != ERR_NONE) |-> out_o.last)
    else $error("error code on a non-final result");

  // A good frame carries no error code and closes the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.good |-> out_o.last && (out_o.error_code == ERR_NONE))
    else $error("good flag with error or without last");

  // An empty result register never stalls the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled while result register empty");

  // An accepted byte that produces a result shows up as valid on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && step.valid |=> out_o.valid)
    else $error("result lost after accepted byte");

endmodule

`default_nettype wire

/* tb/sv/tb_carrier_frame_receiver.sv */
// Self-checking testbench for the carrier frame receiver deframer.
`timescale 1ns / 100ps

module tb_carrier_frame_receiver;
  import cfr_pkg::*;

  // Ways in which a generated frame can be damaged.
  typedef enum int {
    FLAW_NONE,
    FLAW_CHECKSUM,
    FLAW_END,
    FLAW_BOTH,
    FLAW_LENGTH
  } frame_flaw_e;

  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 100;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_data;

  cfr_in_if  in_if ();
  cfr_out_if out_if ();

  carrier_frame_receiver uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #2 clk_i = ~clk_i;

  // Bytes waiting to be sent, and results the deframer still owes us.
  logic [7:0]  tx_bytes[$];
  logic [7:0]  frame_q[$];
  cfr_result_t frame_results[$];

  int n_sent;
  int n_taken;
  int n_results;
  int n_errors;
  int n_good;
  int n_bad[4];
  int stall_cycles;
  bit no_gaps;

  // Shadow of the deframer state and its registers.
  cfr_phase_e  rx_phase;
  logic [15:0] rx_left;
  logic [15:0] rx_pos;
  logic [15:0] rx_len;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_chk;
  logic [1:0]  shadow_len_bytes;
  logic [15:0] shadow_max_len;

  // Advance the deframer shadow by one received byte; returns 1 when a
  // result is produced for it.
  function automatic bit deframe_byte(input logic [7:0] b, output cfr_result_t res);
    logic [15:0] pos;
    logic [16:0] min_len;
    bit          hit;
    res = '0;
    res.out_byte = b;
    hit = 1'b1;
    case (rx_phase)
      PH_LEN: begin
        pos = rx_pos;
        if (pos == 16'd1) begin
          rx_len = {8'h00, b};
        end else begin
          rx_len = rx_len | {b, 8'h00};
        end
        rx_pos = rx_pos + 16'd1;
        rx_left = rx_left - 16'd1;
        res.position = pos;
        if (rx_left == 16'd0) begin
          // The length field is complete: check it against the limits.
          min_len = MIN_LENGTH_BASE + pos;
          if ({1'b0, rx_len} < min_len || rx_len > shadow_max_len) begin
            rx_phase = PH_HUNT;
            res.last = 1'b1;
            res.error_code = ERR_LENGTH;
          end else begin
            rx_left = rx_len - 16'd1 - pos;
            rx_sum = 8'h00;
            rx_chk = 8'h00;
            rx_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        pos = rx_pos;
        rx_pos = rx_pos + 16'd1;
        if (rx_left >= 16'd3) begin
          rx_sum = rx_sum + b;
        end else if (rx_left == 16'd2) begin
          rx_chk = b;
        end
        rx_left = rx_left - 16'd1;
        res.position = pos;
        if (rx_left == 16'd0) begin
          // Trailer: checksum first, then the end byte.
          res.last = 1'b1;
          if (rx_chk != rx_sum) begin
            res.error_code = ERR_CHECKSUM;
          end else if (b != END_BYTE) begin
            res.error_code = ERR_END_BYTE;
          end
          res.good = (res.error_code == ERR_NONE);
          rx_phase = PH_HUNT;
        end
      end
      default: begin
        rx_phase = PH_HUNT;
        if (b != START_BYTE) begin
          hit = 1'b0;
        end else begin
          rx_pos = 16'd1;
          rx_len = 16'd0;
          rx_sum = 8'h00;
          rx_chk = 8'h00;
          rx_left = shadow_len_bytes[1] ? 16'd2 : 16'd1;
          rx_phase = PH_LEN;
          res.position = 16'd0;
        end
      end
    endcase
    return hit;
  endfunction

  task log_mismatch(input string msg);
    if (n_errors < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    n_errors++;
  endtask

  task check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                             n_results, name, got, want));
    end
  endtask

  // Byte driver: feeds the input channel from the queue of pending bytes.
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    cfr_result_t res;
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        n_taken++;
        if (deframe_byte(in_if.in_byte, res)) begin
          frame_results.push_back(res);
          if (res.last) begin
            if (res.good) begin
              n_good++;
            end else begin
              n_bad[res.error_code]++;
            end
          end
        end
      end
      if (!in_if.valid || in_if.ready) begin
        if (tx_bytes.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 29)) begin
          in_if.valid   <= 1'b1;
          in_if.in_byte <= tx_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each result transaction with the oldest expected one.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    cfr_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (frame_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result: byte 0x%0h at position %0d",
                                 out_if.out_byte, out_if.position));
        end else begin
          want = frame_results.pop_front();
          check_field("out_byte", {8'h00, out_if.out_byte}, {8'h00, want.out_byte});
          check_field("position", out_if.position, want.position);
          check_field("last", {15'd0, out_if.last}, {15'd0, want.last});
          check_field("good", {15'd0, out_if.good}, {15'd0, want.good});
          check_field("error_code", {14'd0, out_if.error_code}, {14'd0, want.error_code});
        end
        n_results++;
      end
      out_if.ready <= no_gaps || ($urandom_range(0, 99) >= 29);
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
        stall_cycles = 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d idle cycles", stall_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles++;
      end
    end
  end

  task send(input logic [7:0] b);
    tx_bytes.push_back(b);
    n_sent++;
  endtask

  function automatic int len_field_bytes();
    return shadow_len_bytes[1] ? 2 : 1;
  endfunction

  // Line noise never contains a start byte, so it cannot open a frame.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == START_BYTE) begin
      b = b ^ 8'h01;
    end
    return b;
  endfunction

  // Body bytes favor the delimiters now and then.
  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 7))
      0: return START_BYTE;
      1: return END_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Build one frame of length flen into frame_q; a FLAW_LENGTH frame is header and noise.
  task build_frame(input int unsigned flen, input frame_flaw_e flaw);
    int         nlen;
    int         nbody;
    logic [7:0] sum;
    logic [7:0] b;
    nlen = len_field_bytes();
    frame_q.delete();
    frame_q.push_back(START_BYTE);
    frame_q.push_back(flen[7:0]);
    if (nlen == 2) begin
      frame_q.push_back(flen[15:8]);
    end
    if (flaw == FLAW_LENGTH) begin
      repeat ($urandom_range(0, 4)) frame_q.push_back(noise_byte());
    end else begin
      sum = 8'h00;
      nbody = int'(flen) - nlen - 3;
      repeat (nbody) begin
        b = body_byte();
        sum = sum + b;
        frame_q.push_back(b);
      end
      if (flaw == FLAW_CHECKSUM || flaw == FLAW_BOTH) begin
        sum = sum ^ 8'($urandom_range(1, 255));
      end
      frame_q.push_back(sum);
      if (flaw == FLAW_END || flaw == FLAW_BOTH) begin
        frame_q.push_back(END_BYTE ^ 8'($urandom_range(1, 255)));
      end else begin
        frame_q.push_back(END_BYTE);
      end
    end
  endtask

  task send_frame(input int unsigned flen, input frame_flaw_e flaw);
    build_frame(flen, flaw);
    foreach (frame_q[i]) send(frame_q[i]);
  endtask

  // Wait until every byte is taken and every result has come back.
  task drain();
    while (n_taken != n_sent || frame_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == CFG_IDX_LENGTH_BYTES) begin
      shadow_len_bytes = val[1:0];
    end else begin
      shadow_max_len = val;
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task set_mode(input logic [1:0] len_bytes, input logic [15:0] max_len);
    drain();
    write_reg(CFG_IDX_LENGTH_BYTES, {14'd0, len_bytes});
    write_reg(CFG_IDX_MAX_LENGTH, max_len);
  endtask

  // Random traffic under the current settings: mostly well-formed frames,
  // with damaged frames, cut-off frames and line noise mixed in.
  task run_random(input int n_frame_bytes);
    int          start;
    int unsigned min_len;
    int unsigned top;
    int unsigned hi;
    int unsigned flen;
    int          pick;
    int          cut;
    start = n_sent;
    min_len = 4 + len_field_bytes();
    top = (len_field_bytes() == 2) ? 65535 : 255;
    hi = (shadow_max_len < top) ? shadow_max_len : top;
    while (n_sent - start < n_frame_bytes) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
        flen = $urandom_range(min_len, min_len + 60);
      end else begin
        flen = $urandom_range(min_len, min_len + 10);
      end
      if (flen > hi) begin
        flen = hi;
      end
      if (pick < 65) begin
        send_frame(flen, FLAW_NONE);
      end else if (pick < 75) begin
        send_frame(flen, frame_flaw_e'($urandom_range(FLAW_CHECKSUM, FLAW_BOTH)));
      end else if (pick < 82) begin
        if ($urandom_range(0, 1) == 1 && hi < top) begin
          flen = $urandom_range(hi + 1, (hi + 40 < top) ? hi + 40 : top);
        end else begin
          flen = $urandom_range(0, min_len - 1);
        end
        send_frame(flen, FLAW_LENGTH);
      end else if (pick < 90) begin
        // A frame cut short; the next bytes are taken as its remainder.
        build_frame(flen, FLAW_NONE);
        cut = $urandom_range(1, frame_q.size() - 1);
        for (int i = 0; i < cut; i++) send(frame_q[i]);
      end else begin
        repeat ($urandom_range(1, 5)) begin
          tx_bytes.push_back(noise_byte());
          n_sent++;
          start++;
        end
      end
    end
  endtask

  // Stimulus: directed cases first, then random traffic under several settings.
  initial begin
    in_if.valid      = 1'b0;
    in_if.in_byte    = 8'h00;
    out_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_IDX_LENGTH_BYTES;
    cfg_data         = 16'h0000;
    no_gaps          = 1'b0;
    rst_ni           = 1'b0;
    rx_phase         = PH_HUNT;
    rx_left          = 16'd0;
    rx_pos           = 16'd0;
    rx_len           = 16'd0;
    rx_sum           = 8'h00;
    rx_chk           = 8'h00;
    shadow_len_bytes = LENGTH_BYTES_RESET;
    shadow_max_len   = MAX_LENGTH_RESET;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: noise is dropped, smallest frame with an all-zero body.
    send(8'h00);
    send(8'hFF);
    send(END_BYTE);
    send(START_BYTE); send(8'd5); send(8'h00); send(8'h00); send(END_BYTE);
    // All-ones body, checksum wraps around.
    send(START_BYTE); send(8'd7); send(8'hFF); send(8'hFF); send(8'hFF); send(8'hFD);
    send(END_BYTE);
    // A start byte inside the body is plain data.
    send(START_BYTE); send(8'd6); send(START_BYTE); send(8'h00); send(START_BYTE);
    send(END_BYTE);
    send_frame(6, FLAW_CHECKSUM);
    send_frame(6, FLAW_END);
    send_frame(6, FLAW_BOTH);
    send_frame(4, FLAW_LENGTH);
    send_frame(0, FLAW_LENGTH);
    send_frame(40, FLAW_NONE);

    // A maximum of six admits a frame of that length; one byte over is rejected.
    set_mode(2'd1, 16'd6);
    send_frame(6, FLAW_NONE);
    send_frame(7, FLAW_LENGTH);

    // A maximum below the minimum frame size rejects everything.
    set_mode(2'd1, 16'd4);
    send_frame(5, FLAW_LENGTH);

    // Two length bytes at the widest limit, with a nonzero high length byte.
    set_mode(2'd2, 16'hFFFF);
    send_frame(6, FLAW_NONE);
    send_frame(5, FLAW_LENGTH);
    send_frame(261, FLAW_NONE);
    set_mode(2'd2, 16'hFFFE);
    send_frame(65535, FLAW_LENGTH);

    // Codes 3 and 0 behave as two and one length bytes.
    set_mode(2'd3, 16'd300);
    send_frame(7, FLAW_NONE);
    set_mode(2'd0, 16'd300);
    send_frame(5, FLAW_NONE);

    // A length width change in the middle of a frame applies to the next one.
    build_frame(9, FLAW_NONE);
    for (int i = 0; i < 3; i++) send(frame_q[i]);
    drain();
    write_reg(CFG_IDX_LENGTH_BYTES, 16'd2);
    for (int i = 3; i < frame_q.size(); i++) send(frame_q[i]);
    send_frame(8, FLAW_NONE);

    // Random traffic; the second pass runs with no gaps on either side.
    set_mode(2'd1, 16'($urandom_range(6, 300)));
    run_random(50);
    set_mode(2'd2, 16'hFFFF);
    no_gaps = 1'b1;
    run_random(50);
    drain();
    no_gaps = 1'b0;
    set_mode(2'd3, 16'($urandom_range(6, 1000)));
    run_random(50);
    set_mode(2'd0, 16'd6);
    run_random(50);

    drain();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d results from %0d input bytes.", n_results, n_taken);
    $display("Frames: %0d good, %0d bad length, %0d bad checksum, %0d bad end byte.",
             n_good, n_bad[ERR_LENGTH], n_bad[ERR_CHECKSUM], n_bad[ERR_END_BYTE]);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches found", n_errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
